>>> src/ghash_tag_accumulator_unit_defines.svh
// Assertion macros for the GHASH tag accumulator.
// Included by the top level; no other dependencies.
`ifndef GHASH_TAG_ACCUMULATOR_UNIT_DEFINES_SVH
`define GHASH_TAG_ACCUMULATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define GTAU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gtau assertion failed");
// Checked at every edge, including reset.
`define GTAU_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("gtau assertion failed");
`else
`define GTAU_ASSERT(label, clk, rst_n, prop)
`define GTAU_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> src/gtau_pkg.sv
// Shared types, codes and the GF(2^128) multiply for the GHASH tag accumulator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gtau_pkg;

    localparam int unsigned BLOCK_BYTES = 16;
    localparam int unsigned BLOCK_BITS  = 8 * BLOCK_BYTES;
    localparam int unsigned WORD_BITS   = 64;
    localparam int unsigned COUNT_BITS  = 5;
    localparam int unsigned INCR_BITS   = 8;
    localparam int unsigned ADDR_BITS   = 5;
    localparam logic [7:0]  BYTE_MASK   = 8'hFF;

    typedef enum logic [1:0] {
        CMD_AAD    = 2'd0,
        CMD_TEXT   = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_HASH_KEY_HIGH = 2'd0,
        REG_HASH_KEY_LOW  = 2'd1,
        REG_TAG_MASK_HIGH = 2'd2,
        REG_TAG_MASK_LOW  = 2'd3
    } reg_idx_t;

    // GCM bit order: bit 127 of the vector (MSB of byte 0) is the x^0 coefficient.
    // Carry-less product, then reduction by x^128 = x^7 + x^2 + x + 1.
    function automatic logic [127:0] gf_mul(input logic [127:0] a, input logic [127:0] b);
        logic [127:0] pa;
        logic [127:0] pb;
        logic [254:0] prod;
        logic [134:0] fold;
        logic [127:0] ovf;
        logic [127:0] lo;
        logic [127:0] res;
        for (int i = 0; i < 128; i++) begin
            pa[i] = a[127-i];
            pb[i] = b[127-i];
        end
        prod = '0;
        for (int i = 0; i < 128; i++) begin
            if (pa[i]) begin
                prod = prod ^ ({127'b0, pb} << i);
            end
        end
        // first fold: high half times (x^7 + x^2 + x + 1), degree up to 133
        fold = {8'b0, prod[254:128]} ^ ({8'b0, prod[254:128]} << 1)
             ^ ({8'b0, prod[254:128]} << 2) ^ ({8'b0, prod[254:128]} << 7);
        // second fold: the few bits above x^127, result degree below 14
        ovf = {121'b0, fold[134:128]};
        lo  = prod[127:0] ^ fold[127:0] ^ ovf ^ (ovf << 1) ^ (ovf << 2) ^ (ovf << 7);
        for (int i = 0; i < 128; i++) begin
            res[i] = lo[127-i];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/ghash_tag_accumulator_unit.sv
// A finish transfer is held in the input stage register, then loads the tag register that drives m_tvalid.
// Throughput: one block per cycle; a finish waits only while an earlier tag is not taken.
// The whole GHASH step (Y xor X) * H is one combinational GF(2^128) multiply per cycle.
// Reset (aresetn low, synchronous): accumulator, bit lengths, keys and masks clear to zero,
// both pipeline slots empty.
// Depends on gtau_pkg and ghash_tag_accumulator_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "ghash_tag_accumulator_unit_defines.svh"

module ghash_tag_accumulator_unit
    import gtau_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,

    // input blocks
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,  // [63:0] data_high, [127:64] data_low,
                                        // [132:128] byte_count, [135:133] zero
    input  wire logic [1:0]   s_tuser,  // [1:0] command

    // tags
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,  // [63:0] tag_high, [127:64] tag_low

    // register port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [63:0]          pwdata,
    output logic [63:0]               prdata,
    output logic                      pready
);

    // ------------------------------------------------------------------
    // Configuration registers: 64-bit, byte address 8 * index.
    // ------------------------------------------------------------------
    logic [WORD_BITS-1:0] hkey_hi_reg, hkey_lo_reg, tmask_hi_reg, tmask_lo_reg;
    reg_idx_t             cfg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hkey_hi_reg  <= '0;
            hkey_lo_reg  <= '0;
            tmask_hi_reg <= '0;
            tmask_lo_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_HASH_KEY_HIGH: hkey_hi_reg  <= pwdata;
                REG_HASH_KEY_LOW:  hkey_lo_reg  <= pwdata;
                REG_TAG_MASK_HIGH: tmask_hi_reg <= pwdata;
                REG_TAG_MASK_LOW:  tmask_lo_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HASH_KEY_HIGH: prdata = hkey_hi_reg;
            REG_HASH_KEY_LOW:  prdata = hkey_lo_reg;
            REG_TAG_MASK_HIGH: prdata = tmask_hi_reg;
            REG_TAG_MASK_LOW:  prdata = tmask_lo_reg;
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input stage: decode command, saturate count, zero the tail bytes.
    // Unused commands and empty blocks are dropped here.
    // ------------------------------------------------------------------
    cmd_t                  in_cmd;
    logic [COUNT_BITS-1:0] in_cnt;
    logic [COUNT_BITS-1:0] in_cnt_sat;
    logic [BLOCK_BITS-1:0] in_mask;
    logic                  in_keep;
    logic                  s_xfer;

    assign in_cmd     = cmd_t'(s_tuser);
    assign in_cnt     = s_tdata[132:128];
    assign in_cnt_sat = (in_cnt > COUNT_BITS'(BLOCK_BYTES)) ? COUNT_BITS'(BLOCK_BYTES) : in_cnt;
    assign in_keep    = (in_cmd == CMD_FINISH) ||
                        ((in_cmd inside {CMD_AAD, CMD_TEXT}) && (in_cnt != '0));
    assign s_xfer     = s_tvalid && s_tready;

    // byte 0 sits in the top byte of data_high
    always_comb begin
        for (int b = 0; b < BLOCK_BYTES; b++) begin
            in_mask[BLOCK_BITS-1-8*b -: 8] =
                (COUNT_BITS'(b) < in_cnt_sat) ? BYTE_MASK : 8'h00;
        end
    end

    logic                  s1_vld_reg, s1_vld_next;
    logic                  s1_fin_reg;
    logic                  s1_txt_reg;
    logic [BLOCK_BITS-1:0] s1_blk_reg;
    logic [INCR_BITS-1:0]  s1_incr_reg;
    logic                  s1_fire;

    // A held block always moves on; a finish needs the tag slot free.
    assign s1_fire     = s1_vld_reg && (!s1_fin_reg || !m_tvalid || m_tready);
    assign s_tready    = !s1_vld_reg || s1_fire;
    assign s1_vld_next = s_xfer ? in_keep : (s1_vld_reg && !s1_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= s1_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_fin_reg  <= (in_cmd == CMD_FINISH);
            s1_txt_reg  <= (in_cmd == CMD_TEXT);
            s1_blk_reg  <= {s_tdata[63:0], s_tdata[127:64]} & in_mask;
            s1_incr_reg <= {in_cnt_sat, 3'b000};
        end
    end

    // ------------------------------------------------------------------
    // GHASH stage: Y = (Y xor X) * H, X is the block or the length block.
    // ------------------------------------------------------------------
    logic [BLOCK_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0]  aad_len_reg, aad_len_next;
    logic [WORD_BITS-1:0]  txt_len_reg, txt_len_next;
    logic [BLOCK_BITS-1:0] gh_x;
    logic [BLOCK_BITS-1:0] gh_y;

    assign gh_x = s1_fin_reg ? {aad_len_reg, txt_len_reg} : s1_blk_reg;
    assign gh_y = gf_mul(acc_reg ^ gh_x, {hkey_hi_reg, hkey_lo_reg});

    always_comb begin
        acc_next     = acc_reg;
        aad_len_next = aad_len_reg;
        txt_len_next = txt_len_reg;
        if (s1_fire) begin
            if (s1_fin_reg) begin
                acc_next     = '0;
                aad_len_next = '0;
                txt_len_next = '0;
            end else begin
                acc_next = gh_y;
                if (s1_txt_reg) begin
                    txt_len_next = txt_len_reg + WORD_BITS'(s1_incr_reg);
                end else begin
                    aad_len_next = aad_len_reg + WORD_BITS'(s1_incr_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            aad_len_reg <= '0;
            txt_len_reg <= '0;
        end else begin
            acc_reg     <= acc_next;
            aad_len_reg <= aad_len_next;
            txt_len_reg <= txt_len_next;
        end
    end

    // ------------------------------------------------------------------
    // Tag register: final hash xor E(K, J0).
    // ------------------------------------------------------------------
    logic                  m_vld_reg, m_vld_next;
    logic [BLOCK_BITS-1:0] tag_reg;
    logic                  tag_load;

    assign tag_load   = s1_fire && s1_fin_reg;
    assign m_vld_next = tag_load || (m_vld_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else begin
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_load) begin
            tag_reg <= gh_y ^ {tmask_hi_reg, tmask_lo_reg};
        end
    end

    assign m_tvalid = m_vld_reg;
    // tag_high in the low half of tdata
    assign m_tdata  = {tag_reg[63:0], tag_reg[127:64]};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `GTAU_ASSERT(a_fin_gives_tag, aclk, aresetn, tag_load |=> m_vld_reg)
    `GTAU_ASSERT(a_fin_clears, aclk, aresetn, tag_load |=> (acc_reg == '0 && aad_len_reg == '0 && txt_len_reg == '0))
    `GTAU_ASSERT(a_stall_cause, aclk, aresetn, (s1_vld_reg && !s1_fire) |-> (s1_fin_reg && m_vld_reg && !m_tready))
    `GTAU_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> (!m_vld_reg && !s1_vld_reg))

endmodule

`default_nettype wire

>>> tb/ghash_tag_accumulator_unit_tb.sv
// Self-checking testbench for ghash_tag_accumulator_unit: streams associated data, text and
// finish transfers under random gaps and tag back-pressure, checks each tag against a model.
// Depends on gtau_pkg and the ghash_tag_accumulator_unit RTL.
`timescale 1ns / 1ps

module ghash_tag_accumulator_unit_tb;
    import gtau_pkg::*;

    localparam int           IDLE_PCT       = 38;
    localparam int           RANDOM_ITEMS   = 1900;
    localparam int           RANDOM_PHASES  = 4;
    localparam int           WATCHDOG_LIMIT = 4000;
    localparam int           LONG_HOLD      = 300;
    localparam int           SETTLE_CYCLES  = 4;
    localparam logic [127:0] GCM_POLY       = {8'hE1, 120'b0};

    typedef struct packed {
        logic [63:0] tag_high;
        logic [63:0] tag_low;
    } tag_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [135:0]         s_tdata;   // [63:0] data_high, [127:64] data_low, [132:128] byte_count
    logic [1:0]           s_tuser;   // [1:0] command
    logic                 m_tvalid;
    logic                 m_tready;
    logic [127:0]         m_tdata;   // [63:0] tag_high, [127:64] tag_low
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [63:0]          pwdata;
    logic [63:0]          prdata;
    logic                 pready;

    // GHASH model state and register copies
    logic [127:0] key_h;
    logic [127:0] mask_j0;
    logic [127:0] ghash_acc;
    logic [63:0]  aad_bits;
    logic [63:0]  text_bits;
    tag_t         pending_tags[$];

    int errors;
    int tags_checked;
    int blocks_hashed;
    int transfers_ignored;
    int items_done;
    int key_settings;
    int idle_cycles;
    int hold_requests;
    int holds_served;
    bit gaps_on = 1'b1;

    ghash_tag_accumulator_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
        errors++;
    endtask

    // Bit-serial GF(2^128) product, GCM bit order: x[127] is the x^0 coefficient.
    function automatic logic [127:0] gf128_mult(logic [127:0] x, logic [127:0] y);
        logic [127:0] prod;
        logic [127:0] v;
        prod = '0;
        v    = y;
        for (int i = 127; i >= 0; i--) begin
            if (x[i]) prod ^= v;
            v = v[0] ? ((v >> 1) ^ GCM_POLY) : (v >> 1);
        end
        return prod;
    endfunction

    // Advance the model by one accepted transfer; a finish queues the expected tag.
    function automatic void hash_transfer(cmd_t cmd, logic [63:0] dh, logic [63:0] dl,
                                          logic [4:0] cnt);
        logic [127:0] keep;
        int unsigned  nbytes;
        nbytes = (cnt > BLOCK_BYTES) ? BLOCK_BYTES : cnt;
        case (cmd)
            CMD_FINISH: begin
                ghash_acc = gf128_mult(ghash_acc ^ {aad_bits, text_bits}, key_h);
                pending_tags.insert(pending_tags.size(), ghash_acc ^ mask_j0);
                ghash_acc = '0;
                aad_bits  = '0;
                text_bits = '0;
                items_done++;
            end
            CMD_AAD, CMD_TEXT: begin
                if (nbytes == 0) begin
                    transfers_ignored++;
                end else begin
                    // keep the leading bytes, zero the tail
                    keep      = ~128'b0 << (8 * (BLOCK_BYTES - nbytes));
                    ghash_acc = gf128_mult(ghash_acc ^ ({dh, dl} & keep), key_h);
                    if (cmd == CMD_AAD) aad_bits += 64'(8 * nbytes);
                    else text_bits += 64'(8 * nbytes);
                    blocks_hashed++;
                    items_done++;
                end
            end
            default: transfers_ignored++;
        endcase
    endfunction

    // Starts and ends at a falling edge; the model advances at the accepting edge.
    task automatic send_transfer(cmd_t cmd, logic [63:0] dh, logic [63:0] dl, logic [4:0] cnt);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, cnt, dl, dh};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        hash_transfer(cmd, dh, dl, cnt);
        @(negedge aclk);
    endtask

    // One register access, setup then access phase, followed by an idle gap with psel low.
    task automatic apb_access(bit is_write, reg_idx_t idx, logic [63:0] wdata);
        logic [63:0] model_val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_BITS'({idx, 3'b000});
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (is_write) begin
            case (idx)
                REG_HASH_KEY_HIGH: key_h[127:64]   = wdata;
                REG_HASH_KEY_LOW:  key_h[63:0]     = wdata;
                REG_TAG_MASK_HIGH: mask_j0[127:64] = wdata;
                default:           mask_j0[63:0]   = wdata;
            endcase
        end else begin
            case (idx)
                REG_HASH_KEY_HIGH: model_val = key_h[127:64];
                REG_HASH_KEY_LOW:  model_val = key_h[63:0];
                REG_TAG_MASK_HIGH: model_val = mask_j0[127:64];
                default:           model_val = mask_j0[63:0];
            endcase
            if (prdata !== model_val) report_mismatch("register readback", model_val, prdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Load H and E(K,J0), then read all four back.
    task automatic set_regs(logic [127:0] h, logic [127:0] m);
        apb_access(1'b1, REG_HASH_KEY_HIGH, h[127:64]);
        apb_access(1'b1, REG_HASH_KEY_LOW,  h[63:0]);
        apb_access(1'b1, REG_TAG_MASK_HIGH, m[127:64]);
        apb_access(1'b1, REG_TAG_MASK_LOW,  m[63:0]);
        apb_access(1'b0, REG_HASH_KEY_HIGH, '0);
        apb_access(1'b0, REG_HASH_KEY_LOW,  '0);
        apb_access(1'b0, REG_TAG_MASK_HIGH, '0);
        apb_access(1'b0, REG_TAG_MASK_LOW,  '0);
        key_settings++;
    endtask

    // Stop offering, wait for every tag, then let the block settle before registers change.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_tags.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [63:0] random_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [127:0] random_block();
        return {random_word(), random_word()};
    endfunction

    // Mostly legal partial counts, now and then a count that saturates.
    function automatic logic [4:0] random_count();
        if ($urandom_range(7) == 0) return 5'($urandom_range(17, 31));
        return 5'($urandom_range(1, 16));
    endfunction

    task automatic test_register_port();
        apb_access(1'b0, REG_HASH_KEY_HIGH, '0);
        apb_access(1'b0, REG_TAG_MASK_LOW,  '0);
        set_regs('1, '1);
        set_regs('0, '0);
    endtask

    task automatic test_directed();
        // known GCM vector: one full text block under a zero key
        set_regs(128'h66e94bd4ef8a2c3b884cfa59ca342b2e,
                 128'h58e2fccefa7e3061367f1d57a4e7455a);
        send_transfer(CMD_TEXT, 64'h0388dace60b6a392, 64'hf328c2b971b2fe78, 5'd16);
        send_transfer(CMD_FINISH, '0, '0, 5'd0);
        send_transfer(CMD_FINISH, '1, '1, 5'd31);   // empty message, junk payload
        drain();

        set_regs('1, '1);
        send_transfer(CMD_AAD,  '1, '1, 5'd16);
        send_transfer(CMD_AAD,  '0, '0, 5'd1);
        send_transfer(CMD_TEXT, '1, '1, 5'd8);
        send_transfer(CMD_TEXT, '1, '1, 5'd9);
        send_transfer(CMD_TEXT, '1, '1, 5'd15);
        send_transfer(CMD_TEXT, '1, '1, 5'd17);     // saturates to a full block
        send_transfer(CMD_AAD,  '1, '1, 5'd31);     // data after text, saturating count
        send_transfer(CMD_AAD,  '1, '1, 5'd0);      // zero count: dropped
        send_transfer(CMD_TEXT, '1, '1, 5'd0);
        send_transfer(CMD_UNUSED, '1, '1, 5'd16);   // unused command: dropped
        send_transfer(CMD_FINISH, '1, '1, 5'd16);
        send_transfer(CMD_TEXT, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd7);
        send_transfer(CMD_FINISH, '0, '0, 5'd0);
        drain();

        // zero key and mask: every tag must come out zero
        set_regs('0, '0);
        send_transfer(CMD_TEXT, random_word(), random_word(), 5'd7);
        send_transfer(CMD_FINISH, '0, '0, 5'd0);
        drain();
    endtask

    // Receiver stops for a long stretch while short messages keep coming.
    task automatic test_long_hold();
        set_regs(random_block(), random_block());
        hold_requests++;
        for (int i = 0; i < 20; i++) begin
            send_transfer(CMD_TEXT, random_word(), random_word(), random_count());
            send_transfer(CMD_FINISH, random_word(), random_word(), 5'($urandom));
        end
        drain();
    endtask

    // Well-formed message with random content, occasionally salted with noise.
    task automatic send_message();
        int n_aad;
        int n_text;
        n_aad  = $urandom_range(3);
        n_text = $urandom_range(6);
        for (int i = 0; i < n_aad; i++)
            send_transfer(CMD_AAD, random_word(), random_word(),
                          (i == n_aad - 1) ? random_count() : 5'd16);
        for (int i = 0; i < n_text; i++)
            send_transfer(CMD_TEXT, random_word(), random_word(),
                          (i == n_text - 1) ? random_count() : 5'd16);
        case ($urandom_range(11))
            0: send_transfer(CMD_UNUSED, random_word(), random_word(), 5'($urandom));
            1: send_transfer(($urandom_range(1) != 0) ? CMD_TEXT : CMD_AAD,
                             random_word(), random_word(), 5'd0);
            2: send_transfer(CMD_AAD, random_word(), random_word(), random_count());
            default: ;
        endcase
        send_transfer(CMD_FINISH, random_word(), random_word(), 5'($urandom));
    endtask

    task automatic test_random_messages();
        int target;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_regs(random_block(), random_block());
            gaps_on = (p != 1);             // second phase runs with no idling on either side
            target  = items_done + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_done < target) send_message();
            drain();
        end
        gaps_on = 1'b1;
    endtask

    // Tag receiver: random stalls, plus the long hold-off when one is requested.
    initial begin : tag_receiver
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin : check_tags
        tag_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tags.size() == 0) begin
                report_mismatch("tag with none outstanding", '0, m_tdata[63:0]);
            end else begin
                want = pending_tags.pop_front();
                if (m_tdata[63:0] !== want.tag_high)
                    report_mismatch("tag_high", want.tag_high, m_tdata[63:0]);
                if (m_tdata[127:64] !== want.tag_low)
                    report_mismatch("tag_low", want.tag_low, m_tdata[127:64]);
                tags_checked++;
            end
        end
    end

    // Watchdog: cycles in a row with no transfer on any port.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] timeout: no transfer for %0d cycles", $realtime, idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_AAD;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        key_h     = '0;
        mask_j0   = '0;
        ghash_acc = '0;
        aad_bits  = '0;
        text_bits = '0;
        aresetn   = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_register_port();
        test_directed();
        test_long_hold();
        test_random_messages();
        drain();

        $display("Covered %0d hashed blocks, %0d dropped transfers, %0d tags",
                 blocks_hashed, transfers_ignored, tags_checked);
        $display("over %0d key settings, with random gaps, a gap-free phase and a %0d-cycle hold.",
                 key_settings, LONG_HOLD);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/gtau_pkg.sv
src/ghash_tag_accumulator_unit.sv
tb/ghash_tag_accumulator_unit_tb.sv
